// File: src/lrmrs_pkg.sv
// lrmrs_pkg: shared types and constants for the lidar roi min range stats unit
// no dependencies

package lrmrs_pkg;

	localparam int RANGE_BITS   = 16;
	localparam int ANGLE_BITS   = 16;
	localparam int COUNT_BITS   = 16;
	localparam int CORDIC_STEPS = 14;
	localparam int CW           = 18;   // cordic datapath width
	localparam int DIV_BITS     = 48;   // widest dividend (square total)
	localparam logic [CW-1:0] CORDIC_GAIN = CW'(9949);

	localparam logic [2:0] REG_START  = 3'd0;
	localparam logic [2:0] REG_STEP   = 3'd1;
	localparam logic [2:0] REG_XLOW   = 3'd2;
	localparam logic [2:0] REG_XHIGH  = 3'd3;
	localparam logic [2:0] REG_YLOW   = 3'd4;
	localparam logic [2:0] REG_YHIGH  = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_MUL,
		ST_CHECK,
		ST_ACC,
		ST_DIV_MEAN,
		ST_DIV_SQ,
		ST_MSQ,
		ST_FINISH,
		ST_OUT
	} state_t;

	function automatic logic [CW-1:0] atan_lut(input logic [3:0] i);
		logic [CW-1:0] v;
		case (i)
			4'd0:    v = CW'(8192);
			4'd1:    v = CW'(4836);
			4'd2:    v = CW'(2555);
			4'd3:    v = CW'(1297);
			4'd4:    v = CW'(651);
			4'd5:    v = CW'(326);
			4'd6:    v = CW'(163);
			4'd7:    v = CW'(81);
			4'd8:    v = CW'(41);
			4'd9:    v = CW'(20);
			4'd10:   v = CW'(10);
			4'd11:   v = CW'(5);
			4'd12:   v = CW'(3);
			4'd13:   v = CW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: src/lidar_roi_min_range_stats_unit.sv
// lidar_roi_min_range_stats_unit: top level, beam geometry, region minimum and scan stats
// depends on lrmrs_pkg
//
// channel  direction  handshake        payload
// in       input      in_valid/in_stall  range_mm, scan_end
// out      output     out_valid/out_stall detected .. variance_mm2
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// a beam is accepted in idle, then takes 14 cordic iterations, 16 shift-add
// multiply steps for x and y together and a region check; the time from one beam
// to the next is set by the cordic loop and the serial multiplier
// a scan_end beam adds the accumulate state, two 48-step restoring divides, a
// 16-step squaring and the finish and publish states
// reset clears control and accumulators; a held result does not block the next
// beam, but a scan_end beam waits in the check state until that result is taken

module lidar_roi_min_range_stats_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [15:0]         range_mm,
	input  logic                scan_end,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                detected,
	output logic [15:0]         scan_min_mm,
	output logic [15:0]         scan_count,
	output logic                stats_valid,
	output logic [15:0]         mean_mm,
	output logic [31:0]         variance_mm2,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int RB = lrmrs_pkg::RANGE_BITS;
	localparam int AB = lrmrs_pkg::ANGLE_BITS;
	localparam int CB = lrmrs_pkg::COUNT_BITS;
	localparam int CW = lrmrs_pkg::CW;
	localparam int DB = lrmrs_pkg::DIV_BITS;
	localparam int PW = RB + CW;            // product width

	// configuration registers
	logic [15:0] start_angle_q, angle_step_q;
	logic signed [15:0] x_low_q, x_high_q, y_low_q, y_high_q;

	// scan state
	logic [AB-1:0]  beam_angle_q;
	logic [RB-1:0]  running_min_q;
	logic           seen_q;
	logic [31:0]    range_total_q;
	logic [47:0]    square_total_q;
	logic [CB-1:0]  scans_q;

	lrmrs_pkg::state_t state_q, state_d;

	// beam working registers
	logic [RB-1:0]        r_q;
	logic                 end_q;
	logic                 flip_q;
	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic [5:0]           step_q;
	// serial multiply: multiplier r shifts out one bit per cycle, both x and y
	logic [RB-1:0]        mr_q;
	logic signed [PW:0]   px_q, py_q;
	// serial divide and squaring
	logic [DB-1:0]        dq_q;     // dividend shifting into quotient
	logic [DB:0]          drem_q;   // partial remainder
	logic [31:0]          mean_q;
	logic [47:0]          q2_q;
	logic [31:0]          sqa_q;    // square multiplicand
	logic [15:0]          sqb_q;    // multiplier bits
	logic [63:0]          msq_q;

	logic in_acc, out_acc, res_full_q;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != lrmrs_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign out_valid = res_full_q;

	// cordic step combinational part
	logic signed [CW-1:0] dx, dy, at;
	assign dx = cy_q >>> step_q[3:0];
	assign dy = cx_q >>> step_q[3:0];
	assign at = lrmrs_pkg::atan_lut(step_q[3:0]);

	// phase fold at acceptance
	logic [AB-1:0] ang;
	logic [15:0]   ph, phf;
	logic          flip;
	assign ang  = AB'(start_angle_q) + beam_angle_q;
	assign ph   = 16'((24'(ang) << (24 - AB)) >> 8);
	assign flip = ph[15] ^ ph[14];
	assign phf  = flip ? (ph - 16'h8000) : ph;

	// signed cos/sin after flip
	logic signed [CW-1:0] cs, sn;
	assign cs = flip_q ? -cx_q : cx_q;
	assign sn = flip_q ? -cy_q : cy_q;

	// product add for serial multiply
	logic signed [PW:0] addx, addy;
	assign addx = mr_q[0] ? (PW+1)'(cx_q) <<< step_q[4:0] : '0;
	assign addy = mr_q[0] ? (PW+1)'(cy_q) <<< step_q[4:0] : '0;

	// region test on products (floor shift by 14)
	logic signed [PW-14:0] xm, ym;
	logic in_roi;
	assign xm = px_q[PW:14];
	assign ym = py_q[PW:14];
	assign in_roi = (xm >= (PW-13)'(x_low_q)) && (xm <= (PW-13)'(x_high_q))
		&& (ym >= (PW-13)'(y_low_q)) && (ym <= (PW-13)'(y_high_q));

	// saturating accumulate of the scan minimum
	logic          acc_en;
	logic [2*RB-1:0] min_sq;
	logic [32:0]   rt_sum;
	logic [48:0]   st_sum;
	logic [31:0]   rt_next;
	logic [47:0]   st_next;
	assign acc_en  = seen_q && (scans_q != '1);
	assign min_sq  = (2*RB)'(running_min_q) * (2*RB)'(running_min_q);
	assign rt_sum  = 33'(range_total_q) + 33'(running_min_q);
	assign st_sum  = 49'(square_total_q) + 49'(min_sq);
	assign rt_next = !acc_en ? range_total_q : (rt_sum[32] ? 32'hFFFF_FFFF : rt_sum[31:0]);
	assign st_next = !acc_en ? square_total_q
		: (st_sum[48] ? 48'hFFFF_FFFF_FFFF : st_sum[47:0]);

	// restoring divide step, divisor is scans_q
	logic [DB:0]   trial;
	logic [DB-1:0] quo;
	assign trial = {drem_q[DB-1:0], dq_q[DB-1]} - (DB+1)'(scans_q);
	assign quo   = {dq_q[DB-2:0], !trial[DB]};

	logic cnt_gt1;
	assign cnt_gt1 = (scans_q > CB'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			lrmrs_pkg::ST_IDLE:     if (in_acc) state_d = lrmrs_pkg::ST_CORDIC;
			lrmrs_pkg::ST_CORDIC:   if (step_q == 6'(lrmrs_pkg::CORDIC_STEPS - 1))
				state_d = lrmrs_pkg::ST_MUL;
			lrmrs_pkg::ST_MUL:      if (step_q == 6'(RB - 1)) state_d = lrmrs_pkg::ST_CHECK;
			// a scan end waits here while the previous result is still held
			lrmrs_pkg::ST_CHECK: begin
				if (!end_q) state_d = lrmrs_pkg::ST_IDLE;
				else if (!res_full_q || out_acc) state_d = lrmrs_pkg::ST_ACC;
			end
			lrmrs_pkg::ST_ACC:      state_d = lrmrs_pkg::ST_DIV_MEAN;
			lrmrs_pkg::ST_DIV_MEAN: if (step_q == 6'(DB - 1)) state_d = lrmrs_pkg::ST_DIV_SQ;
			lrmrs_pkg::ST_DIV_SQ:   if (step_q == 6'(DB - 1)) state_d = lrmrs_pkg::ST_MSQ;
			lrmrs_pkg::ST_MSQ:      if (step_q == 6'd15) state_d = lrmrs_pkg::ST_FINISH;
			lrmrs_pkg::ST_FINISH:   state_d = lrmrs_pkg::ST_OUT;
			lrmrs_pkg::ST_OUT:      state_d = lrmrs_pkg::ST_IDLE;
			default:                state_d = lrmrs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrmrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= 16'd0;
			angle_step_q  <= 16'd182;
			x_low_q       <= 16'sd100;
			x_high_q      <= 16'sd1000;
			y_low_q       <= -16'sd400;
			y_high_q      <= 16'sd400;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lrmrs_pkg::REG_START: start_angle_q <= cfg_data;
				lrmrs_pkg::REG_STEP:  angle_step_q  <= cfg_data;
				lrmrs_pkg::REG_XLOW:  x_low_q       <= cfg_data;
				lrmrs_pkg::REG_XHIGH: x_high_q      <= cfg_data;
				lrmrs_pkg::REG_YLOW:  y_low_q       <= cfg_data;
				lrmrs_pkg::REG_YHIGH: y_high_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// datapath and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_angle_q   <= '0;
			running_min_q  <= '1;
			seen_q         <= 1'b0;
			range_total_q  <= '0;
			square_total_q <= '0;
			scans_q        <= '0;
			res_full_q     <= 1'b0;
			step_q         <= '0;
		end else begin
			if (out_acc) res_full_q <= 1'b0;
			case (state_q)
				lrmrs_pkg::ST_IDLE: begin
					if (in_acc) begin
						r_q          <= RB'(range_mm);
						end_q        <= scan_end;
						flip_q       <= flip;
						cx_q         <= lrmrs_pkg::CORDIC_GAIN;
						cy_q         <= '0;
						cz_q         <= CW'(signed'(phf));
						step_q       <= '0;
						beam_angle_q <= beam_angle_q + AB'(angle_step_q);
					end
				end
				lrmrs_pkg::ST_CORDIC: begin
					if (!cz_q[CW-1]) begin
						cx_q <= cx_q - dx; cy_q <= cy_q + dy; cz_q <= cz_q - at;
					end else begin
						cx_q <= cx_q + dx; cy_q <= cy_q - dy; cz_q <= cz_q + at;
					end
					if (step_q == 6'(lrmrs_pkg::CORDIC_STEPS - 1)) begin
						step_q <= '0;
						mr_q   <= r_q;
						px_q   <= '0;
						py_q   <= '0;
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				lrmrs_pkg::ST_MUL: begin
					// cx/cy hold final cordic values; apply fold sign on first step
					if (step_q == '0) begin
						cx_q <= cs; cy_q <= sn;
						px_q <= mr_q[0] ? (PW+1)'(cs) : '0;
						py_q <= mr_q[0] ? (PW+1)'(sn) : '0;
					end else begin
						px_q <= px_q + addx;
						py_q <= py_q + addy;
					end
					mr_q   <= mr_q >> 1;
					step_q <= (step_q == 6'(RB - 1)) ? '0 : step_q + 6'd1;
				end
				lrmrs_pkg::ST_CHECK: begin
					if (in_roi) begin
						seen_q <= 1'b1;
						if (r_q < running_min_q) running_min_q <= r_q;
					end
				end
				lrmrs_pkg::ST_ACC: begin
					detected       <= seen_q;
					scan_min_mm    <= seen_q ? 16'(running_min_q) : 16'd0;
					range_total_q  <= rt_next;
					square_total_q <= st_next;
					if (acc_en) scans_q <= scans_q + CB'(1);
					beam_angle_q  <= '0;
					running_min_q <= '1;
					seen_q        <= 1'b0;
					step_q        <= '0;
					drem_q        <= '0;
					// mean divide starts from the updated range total
					dq_q          <= DB'(rt_next);
				end
				lrmrs_pkg::ST_DIV_MEAN, lrmrs_pkg::ST_DIV_SQ: begin
					if (step_q == 6'(DB - 1)) begin
						step_q <= '0;
						drem_q <= '0;
						if (state_q == lrmrs_pkg::ST_DIV_MEAN) begin
							mean_q <= 32'(quo);
							dq_q   <= square_total_q;
						end else begin
							q2_q  <= quo;
							sqa_q <= mean_q;
							sqb_q <= 16'(mean_q);
							msq_q <= '0;
						end
					end else begin
						step_q <= step_q + 6'd1;
						drem_q <= trial[DB] ? {drem_q[DB-1:0], dq_q[DB-1]} : trial;
						dq_q   <= quo;
					end
				end
				lrmrs_pkg::ST_MSQ: begin
					// mean never exceeds 16 bits, the largest range, once a scan has been counted
					if (sqb_q[0]) msq_q <= msq_q + (64'(sqa_q) << step_q[3:0]);
					sqb_q  <= sqb_q >> 1;
					step_q <= (step_q == 6'd15) ? '0 : step_q + 6'd1;
				end
				lrmrs_pkg::ST_FINISH: begin
					scan_count  <= 16'(scans_q);
					stats_valid <= cnt_gt1;
					if (!cnt_gt1) begin
						mean_mm      <= '0;
						variance_mm2 <= '0;
					end else begin
						mean_mm <= (mean_q > 32'hFFFF) ? 16'hFFFF : 16'(mean_q);
						if (mean_q > 32'hFFFF || 64'(q2_q) <= msq_q)
							variance_mm2 <= (mean_q > 32'hFFFF && 64'(q2_q) > 64'h1_0000_0000)
								? 32'hFFFF_FFFF : 32'd0;
						else if (64'(q2_q) - msq_q > 64'hFFFF_FFFF)
							variance_mm2 <= 32'hFFFF_FFFF;
						else
							variance_mm2 <= 32'(64'(q2_q) - msq_q);
					end
				end
				lrmrs_pkg::ST_OUT: begin
					// result register is empty here, freed before the accumulate step
					res_full_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_in_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> state_q == lrmrs_pkg::ST_IDLE) else $error("beam taken while busy");
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		scans_q >= $past(scans_q)) else $error("scan count went down");
	a_out_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_full_q) |-> $past(state_q) == lrmrs_pkg::ST_OUT)
		else $error("result without scan end");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(scan_count) && $stable(mean_mm)
		&& $stable(variance_mm2) && $stable(scan_min_mm))
		else $error("stalled result changed");
`endif

endmodule
